// ===== hw/rtl/midi_clock_beat_tracker_defines.svh =====
// Assertion macros used by the checker file of the MIDI clock beat tracker.
// Depends on nothing; a file that uses them names clk and rst_n in its own scope.
`ifndef MIDI_CLOCK_BEAT_TRACKER_DEFINES_SVH
`define MIDI_CLOCK_BEAT_TRACKER_DEFINES_SVH

// Check a property on every clock edge outside reset
`define MCBT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition on one edge implies another on the next edge
`define MCBT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mcbt_pkg.sv =====
// Package of the MIDI clock beat tracker: widths, codes, reset values and types.
// Used by mcbt_div, midi_clock_beat_tracker, mcbt_checker and tb_top; depends on nothing.
`timescale 1ns / 1ps

package mcbt_pkg;

    // Widths of the datapath
    localparam int TIME_WIDTH      = 40;
    localparam int TICK_WIDTH      = 32;
    localparam int FRACTION_BITS   = 16;
    localparam int IV_WIDTH        = 16;
    localparam int CPB_WIDTH       = 8;
    localparam int BEAT_WIDTH      = 56;
    localparam int TOTAL_WIDTH     = 32;
    localparam int NOW_WIDTH       = 40;
    localparam int STATUS_WIDTH    = 8;
    localparam int LEN_WIDTH       = 3;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    // Widths of the beat quotient
    localparam int PROD_WIDTH = TICK_WIDTH + IV_WIDTH;
    localparam int SUM_WIDTH  = ((PROD_WIDTH > TIME_WIDTH) ? PROD_WIDTH : TIME_WIDTH) + 1;
    localparam int NUM_WIDTH  = SUM_WIDTH + FRACTION_BITS;
    localparam int DIV_WIDTH  = IV_WIDTH + CPB_WIDTH;
    localparam int CNT_WIDTH  = $clog2(NUM_WIDTH);

    typedef logic [TIME_WIDTH-1:0] stamp_t;
    typedef logic [NUM_WIDTH-1:0]  num_t;
    typedef logic [DIV_WIDTH-1:0]  den_t;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIN_INTERVAL   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_INTERVAL   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CLOCKS_PER_BEAT = 2'd2;

    // Command codes
    localparam logic CMD_MESSAGE = 1'b0;
    localparam logic CMD_QUERY   = 1'b1;

    // MIDI real-time status bytes
    localparam logic [STATUS_WIDTH-1:0] MIDI_CLOCK = 8'hF8;
    localparam logic [STATUS_WIDTH-1:0] MIDI_START = 8'hFA;
    localparam logic [STATUS_WIDTH-1:0] MIDI_STOP  = 8'hFC;

    // Reset values
    localparam logic [IV_WIDTH-1:0]  RST_MIN_INTERVAL = 16'd25;
    localparam logic [IV_WIDTH-1:0]  RST_MAX_INTERVAL = 16'd666;
    localparam logic [CPB_WIDTH-1:0] RST_CPB          = 8'd6;
    localparam logic [IV_WIDTH-1:0]  RST_INTERVAL     = 16'd83;

endpackage

// ===== hw/rtl/mcbt_div.sv =====
// Bit-serial restoring divider of the beat tracker: one quotient bit per cycle.
// Depends on mcbt_pkg.
`timescale 1ns / 1ps

module mcbt_div
    import mcbt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  num_t numer,
    input  den_t denom,
    output logic done,
    output num_t quotient
);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [CNT_WIDTH-1:0] cnt_reg;
    logic [CNT_WIDTH-1:0] cnt_next;
    num_t                 quo_reg;
    num_t                 quo_next;
    den_t                 rem_reg;
    den_t                 rem_next;
    den_t                 den_reg;
    den_t                 den_next;

    logic [DIV_WIDTH:0]   rem_shift;
    logic [DIV_WIDTH:0]   rem_diff;
    logic                 fits;

    // Shift in the next numerator bit and try the subtraction
    assign rem_shift = {rem_reg, quo_reg[NUM_WIDTH-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign fits      = !rem_diff[DIV_WIDTH];

    // Load on start, then step one bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = numer;
            rem_next  = '0;
            den_next  = denom;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_WIDTH-2:0], fits};
            rem_next = fits ? rem_diff[DIV_WIDTH-1:0] : rem_shift[DIV_WIDTH-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_WIDTH'(NUM_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Hold datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/midi_clock_beat_tracker.sv =====
// MIDI clock beat tracker: usage and timing
// The input channel (in_valid, in_stall) carries one word per item: command selects
// a MIDI message (status_byte, message_length, now_ms) or a beat query at now_ms.
// The output channel (out_valid, out_stall) returns one word per item: beat_q16
// (zero for a message), tick_total and interval_now after the item.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 min interval,
// 1 max interval, 2 beat length in MIDI clock messages); write only while the block is idle.
// A message passes through states DIFF, MSG and OUT from acceptance to out_valid.
// A query passes through DIFF, MUL1 and MUL2, then waits in DIVW while the
// bit-serial divider forms one quotient bit per cycle, and then goes to OUT. One
// shared multiplier forms ticks * interval and interval * clocks per beat in
// MUL1 and MUL2, ahead of the divider. One item is in work at a time: in_stall
// is high from acceptance until the result is loaded into the output register.
// A finished result waits there while out_stall is high, and the next item may
// be accepted meanwhile; it is held before loading until that word has been taken.
// Reset clears the tick count and last clock time, sets the interval to 83 ms
// and the registers to 25, 666 and 6; no clearing pass is needed.
// Depends on mcbt_pkg and mcbt_div.
`timescale 1ns / 1ps

module midi_clock_beat_tracker
    import mcbt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       command,
    input  logic [STATUS_WIDTH-1:0]    status_byte,
    input  logic [LEN_WIDTH-1:0]       message_length,
    input  logic [NOW_WIDTH-1:0]       now_ms,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [BEAT_WIDTH-1:0]      beat_q16,
    output logic [TOTAL_WIDTH-1:0]     tick_total,
    output logic [IV_WIDTH-1:0]        interval_now,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIFF = 3'd1;
    localparam logic [2:0] ST_MSG  = 3'd2;
    localparam logic [2:0] ST_MUL1 = 3'd3;
    localparam logic [2:0] ST_MUL2 = 3'd4;
    localparam logic [2:0] ST_DIVW = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;

    // Configuration and tracker state
    logic [IV_WIDTH-1:0]     min_iv_reg;
    logic [IV_WIDTH-1:0]     max_iv_reg;
    logic [CPB_WIDTH-1:0]    cpb_reg;
    logic [TICK_WIDTH-1:0]   tick_reg;
    logic [TICK_WIDTH-1:0]   tick_next;
    stamp_t                  last_reg;
    stamp_t                  last_next;
    logic [IV_WIDTH-1:0]     iv_reg;
    logic [IV_WIDTH-1:0]     iv_next;

    // Latched input word and working values
    logic                    cmd_reg;
    logic [STATUS_WIDTH-1:0] status_reg;
    logic [LEN_WIDTH-1:0]    len_reg;
    stamp_t                  now_reg;
    stamp_t                  diff_reg;
    stamp_t                  diff_next;
    logic [PROD_WIDTH-1:0]   prod_reg;
    logic [PROD_WIDTH-1:0]   prod_next;
    logic                    is_query_reg;
    logic                    is_query_next;

    // Output register
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [BEAT_WIDTH-1:0]   beat_reg;
    logic [TOTAL_WIDTH-1:0]  total_reg;
    logic [IV_WIDTH-1:0]     ivout_reg;

    logic                    in_accept;
    logic                    out_load;
    logic [IV_WIDTH-1:0]     iv_eff;
    logic [CPB_WIDTH-1:0]    cpb_eff;
    logic [TICK_WIDTH-1:0]   mul_a;
    logic [PROD_WIDTH-1:0]   mul_p;
    logic [SUM_WIDTH-1:0]    sum;
    num_t                    numer;
    logic                    div_start;
    logic                    div_done;
    num_t                    quotient;
    logic                    saturate;
    logic [BEAT_WIDTH-1:0]   beat_value;
    logic                    in_bounds;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    // Zero interval or zero clocks per beat count as one
    assign iv_eff  = (iv_reg == '0) ? IV_WIDTH'(1) : iv_reg;
    assign cpb_eff = (cpb_reg == '0) ? CPB_WIDTH'(1) : cpb_reg;

    // Shared multiplier: ticks * interval, then clocks per beat * interval
    assign mul_a = (state_reg == ST_MUL1) ? tick_reg : TICK_WIDTH'(cpb_eff);
    assign mul_p = PROD_WIDTH'(mul_a) * PROD_WIDTH'(iv_eff);

    // Numerator is (ticks * interval + elapsed) with the fraction bits appended
    assign sum       = SUM_WIDTH'(prod_reg) + SUM_WIDTH'(diff_reg);
    assign numer     = {sum, {FRACTION_BITS{1'b0}}};
    assign div_start = (state_reg == ST_MUL2);

    mcbt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (numer),
        .denom    (mul_p[DIV_WIDTH-1:0]),
        .done     (div_done),
        .quotient (quotient)
    );

    // Saturate the quotient at the top of the beat field
    assign saturate   = (quotient >> BEAT_WIDTH) != '0;
    assign beat_value = saturate ? '1 : BEAT_WIDTH'(quotient);

    assign in_bounds = (stamp_t'(min_iv_reg) <= diff_reg) && (diff_reg <= stamp_t'(max_iv_reg));

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        tick_next     = tick_reg;
        last_next     = last_reg;
        iv_next       = iv_reg;
        diff_next     = diff_reg;
        prod_next     = prod_reg;
        is_query_next = is_query_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                // Elapsed time since the last clock, wrapping
                diff_next     = now_reg - last_reg;
                is_query_next = (cmd_reg == CMD_QUERY);
                state_next    = (cmd_reg == CMD_QUERY) ? ST_MUL1 : ST_MSG;
            end
            ST_MSG:
            begin
                if (len_reg != '0)
                begin
                    if (status_reg == MIDI_CLOCK)
                    begin
                        if (in_bounds)
                        begin
                            iv_next = diff_reg[IV_WIDTH-1:0];
                        end
                        last_next = now_reg;
                        tick_next = tick_reg + 1'b1;
                    end
                    else if (status_reg == MIDI_START || status_reg == MIDI_STOP)
                    begin
                        tick_next = '0;
                    end
                end
                state_next = ST_OUT;
            end
            ST_MUL1:
            begin
                prod_next  = mul_p;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drop the output word once taken, load a new one when done
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Hold control state, tracker state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            tick_reg      <= '0;
            last_reg      <= '0;
            iv_reg        <= RST_INTERVAL;
            min_iv_reg    <= RST_MIN_INTERVAL;
            max_iv_reg    <= RST_MAX_INTERVAL;
            cpb_reg       <= RST_CPB;
            is_query_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            tick_reg      <= tick_next;
            last_reg      <= last_next;
            iv_reg        <= iv_next;
            is_query_reg  <= is_query_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MIN_INTERVAL:    min_iv_reg <= cfg_data[IV_WIDTH-1:0];
                    REG_MAX_INTERVAL:    max_iv_reg <= cfg_data[IV_WIDTH-1:0];
                    REG_CLOCKS_PER_BEAT: cpb_reg    <= cfg_data[CPB_WIDTH-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Capture the input word, working values and the output word
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg    <= command;
            status_reg <= status_byte;
            len_reg    <= message_length;
            now_reg    <= stamp_t'(now_ms);
        end
        diff_reg <= diff_next;
        prod_reg <= prod_next;
        if (out_load)
        begin
            beat_reg  <= is_query_reg ? beat_value : '0;
            total_reg <= TOTAL_WIDTH'(tick_reg);
            ivout_reg <= iv_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign beat_q16     = beat_reg;
    assign tick_total   = total_reg;
    assign interval_now = ivout_reg;

endmodule

// ===== hw/rtl/mcbt_checker.sv =====
// Port-level checker of the MIDI clock beat tracker, bound to the top level.
// Depends on mcbt_pkg and midi_clock_beat_tracker_defines.svh.
`timescale 1ns / 1ps
`include "midi_clock_beat_tracker_defines.svh"

module mcbt_checker
    import mcbt_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [BEAT_WIDTH-1:0]  beat_q16,
    input logic [TOTAL_WIDTH-1:0] tick_total,
    input logic [IV_WIDTH-1:0]    interval_now
);

    // A stalled output word stays offered
    `MCBT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "output word dropped while stalled")

    // A stalled output word keeps its fields
    `MCBT_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(beat_q16) && $stable(tick_total) && $stable(interval_now), "output word changed while stalled")

    // After an accepted word the block is busy
    `MCBT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input not stalled right after acceptance")

    // A new result appears only at the end of work on an item
    `MCBT_ASSERT(a_result_from_work, $rose(out_valid) |-> $past(in_stall), "result offered without an item in work")

endmodule

bind midi_clock_beat_tracker mcbt_checker u_mcbt_checker (.*);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the MIDI clock beat tracker: directed table, then random words.
// Keeps its own model of tick count, last clock time and interval and checks every result.
// Depends on mcbt_pkg and midi_clock_beat_tracker.
`timescale 1ns / 1ps

module tb_top;
    import mcbt_pkg::*;

    localparam int STEPS            = 26;
    localparam int RANDOM_PER_PHASE = 88;
    localparam int RANDOM_PHASES    = 6;
    localparam int QUIET_LIMIT      = 3000;
    localparam int SETTLE_CYCLES    = 80;
    localparam logic [BEAT_WIDTH-1:0] BEAT_FULL_SCALE = '1;

    typedef struct packed {
        logic                    cmd;
        logic [STATUS_WIDTH-1:0] status;
        logic [LEN_WIDTH-1:0]    len;
        logic [NOW_WIDTH-1:0]    now;
    } midi_word_t;

    typedef struct packed {
        logic [BEAT_WIDTH-1:0]  beat;
        logic [TOTAL_WIDTH-1:0] ticks;
        logic [IV_WIDTH-1:0]    iv;
    } beat_report_t;

    // ROW_PREDICT: checked against the model; ROW_TYPED: result typed in the row;
    // ROW_REGS: min, max and clocks per beat ride in the beat, ticks and iv columns
    typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_REGS} row_kind_e;

    typedef struct {
        row_kind_e               kind;
        logic                    cmd;
        logic [STATUS_WIDTH-1:0] status;
        logic [LEN_WIDTH-1:0]    len;
        logic [NOW_WIDTH-1:0]    now;
        logic [BEAT_WIDTH-1:0]   beat;
        logic [TOTAL_WIDTH-1:0]  ticks;
        logic [IV_WIDTH-1:0]     iv;
    } step_row_t;

    logic                       clk;
    logic                       rst_n          = 1'b0;
    logic                       in_valid       = 1'b0;
    logic                       in_stall;
    logic                       command        = CMD_MESSAGE;
    logic [STATUS_WIDTH-1:0]    status_byte    = '0;
    logic [LEN_WIDTH-1:0]       message_length = '0;
    logic [NOW_WIDTH-1:0]       now_ms         = '0;
    logic                       out_valid;
    logic                       out_stall      = 1'b0;
    logic [BEAT_WIDTH-1:0]      beat_q16;
    logic [TOTAL_WIDTH-1:0]     tick_total;
    logic [IV_WIDTH-1:0]        interval_now;
    logic                       cfg_we         = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index      = REG_MIN_INTERVAL;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data       = '0;

    // Tracker state and registers as the block should hold them
    logic [TICK_WIDTH-1:0] tick_cnt   = '0;
    logic [TIME_WIDTH-1:0] last_ms    = '0;
    logic [IV_WIDTH-1:0]   spacing_ms = RST_INTERVAL;
    logic [IV_WIDTH-1:0]   min_ms     = RST_MIN_INTERVAL;
    logic [IV_WIDTH-1:0]   max_ms     = RST_MAX_INTERVAL;
    logic [CPB_WIDTH-1:0]  cpb_reg    = RST_CPB;

    beat_report_t reports_due[$];
    int send_idle_pct    = 11;
    int recv_idle_pct    = 47;
    int words_sent       = 0;
    int results_seen     = 0;
    int mismatches       = 0;
    int settings_written = 0;
    int quiet_cycles     = 0;

    step_row_t script [0:STEPS-1] = '{
        '{ROW_TYPED,   CMD_QUERY,   8'h00,      3'd0, 40'd0,    56'd0,  32'd0, 16'd83},
        '{ROW_TYPED,   CMD_MESSAGE, MIDI_CLOCK, 3'd1, 40'd100,  56'd0,  32'd1, 16'd100},
        '{ROW_TYPED,   CMD_QUERY,   8'h00,      3'd0, 40'd150,  56'd16384, 32'd1, 16'd100},
        // spacing below the minimum, at the maximum, past it, at the minimum
        '{ROW_TYPED,   CMD_MESSAGE, MIDI_CLOCK, 3'd4, 40'd110,  56'd0,  32'd2, 16'd100},
        '{ROW_TYPED,   CMD_MESSAGE, MIDI_CLOCK, 3'd2, 40'd776,  56'd0,  32'd3, 16'd666},
        '{ROW_TYPED,   CMD_MESSAGE, MIDI_CLOCK, 3'd3, 40'd1443, 56'd0,  32'd4, 16'd666},
        '{ROW_TYPED,   CMD_MESSAGE, MIDI_CLOCK, 3'd1, 40'd1468, 56'd0,  32'd5, 16'd25},
        // other status byte and zero length change nothing
        '{ROW_TYPED,   CMD_MESSAGE, 8'h90,      3'd3, 40'd5000, 56'd0,  32'd5, 16'd25},
        '{ROW_TYPED,   CMD_MESSAGE, MIDI_CLOCK, 3'd0, 40'd9000, 56'd0,  32'd5, 16'd25},
        // a query ignores the message fields
        '{ROW_PREDICT, CMD_QUERY,   MIDI_CLOCK, 3'd7, 40'd1500, 56'd0,  32'd0, 16'd0},
        '{ROW_TYPED,   CMD_MESSAGE, MIDI_START, 3'd1, 40'd1500, 56'd0,  32'd0, 16'd25},
        '{ROW_TYPED,   CMD_MESSAGE, MIDI_CLOCK, 3'd1, 40'd1568, 56'd0,  32'd1, 16'd100},
        '{ROW_TYPED,   CMD_MESSAGE, MIDI_STOP,  3'd5, 40'd0,    56'd0,  32'd0, 16'd100},
        // uptime wraps between consecutive clock messages
        '{ROW_TYPED,   CMD_MESSAGE, MIDI_CLOCK, 3'd1, 40'hFF_FFFF_FFCE, 56'd0, 32'd1, 16'd100},
        '{ROW_TYPED,   CMD_MESSAGE, MIDI_CLOCK, 3'd1, 40'd50,   56'd0,  32'd2, 16'd100},
        '{ROW_PREDICT, CMD_QUERY,   8'h00,      3'd0, 40'hFF_FFFF_FFFF, 56'd0, 32'd0, 16'd0},
        // zero minimum allows a zero interval; zero clocks per beat
        '{ROW_REGS,    CMD_MESSAGE, 8'h00,      3'd0, 40'd0,    56'd0,  32'd65535, 16'd0},
        '{ROW_TYPED,   CMD_MESSAGE, MIDI_CLOCK, 3'd1, 40'd50,   56'd0,  32'd3, 16'd0},
        '{ROW_TYPED,   CMD_QUERY,   8'h00,      3'd0, 40'd49,   BEAT_FULL_SCALE, 32'd3, 16'd0},
        '{ROW_PREDICT, CMD_QUERY,   8'h00,      3'd0, 40'd1050, 56'd0,  32'd0, 16'd0},
        // inverted bounds, widest clocks per beat
        '{ROW_REGS,    CMD_MESSAGE, 8'h00,      3'd0, 40'd0,    56'd700, 32'd20, 16'd255},
        '{ROW_TYPED,   CMD_MESSAGE, MIDI_CLOCK, 3'd1, 40'd400,  56'd0,  32'd4, 16'd0},
        '{ROW_PREDICT, CMD_QUERY,   8'h00,      3'd0, 40'd600,  56'd0,  32'd0, 16'd0},
        // both bounds at the top
        '{ROW_REGS,    CMD_MESSAGE, 8'h00,      3'd0, 40'd0,    56'd65535, 32'd65535, 16'd1},
        '{ROW_TYPED,   CMD_MESSAGE, MIDI_CLOCK, 3'd1, 40'd65935, 56'd0, 32'd5, 16'd65535},
        '{ROW_PREDICT, CMD_QUERY,   8'h00,      3'd0, 40'd131469, 56'd0, 32'd0, 16'd0}
    };

    midi_clock_beat_tracker u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .status_byte    (status_byte),
        .message_length (message_length),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .beat_q16       (beat_q16),
        .tick_total     (tick_total),
        .interval_now   (interval_now),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Beat position at a given uptime: exact truncated quotient, saturating
    function automatic logic [BEAT_WIDTH-1:0] beat_at(input logic [NOW_WIDTH-1:0] now);
        logic [TIME_WIDTH-1:0] elapsed;
        logic [IV_WIDTH-1:0]   iv;
        logic [CPB_WIDTH-1:0]  cpb;
        logic [127:0]          num;
        logic [127:0]          quo;
        elapsed = TIME_WIDTH'(now) - last_ms;
        iv      = (spacing_ms == '0) ? IV_WIDTH'(1) : spacing_ms;
        cpb     = (cpb_reg == '0) ? CPB_WIDTH'(1) : cpb_reg;
        num     = (128'(tick_cnt) * 128'(iv) + 128'(elapsed)) << FRACTION_BITS;
        quo     = num / (128'(iv) * 128'(cpb));
        return (quo > 128'(BEAT_FULL_SCALE)) ? BEAT_FULL_SCALE : quo[BEAT_WIDTH-1:0];
    endfunction

    // Advance the tracker state by one word and return the report it produces
    function automatic beat_report_t track_word(input midi_word_t w);
        logic [TIME_WIDTH-1:0] gap;
        beat_report_t          r;
        r.beat = '0;
        if (w.cmd == CMD_QUERY)
        begin
            r.beat = beat_at(w.now);
        end
        else if (w.len != '0)
        begin
            if (w.status == MIDI_CLOCK)
            begin
                gap = TIME_WIDTH'(w.now) - last_ms;
                if (gap >= TIME_WIDTH'(min_ms) && gap <= TIME_WIDTH'(max_ms))
                    spacing_ms = gap[IV_WIDTH-1:0];
                last_ms  = TIME_WIDTH'(w.now);
                tick_cnt = tick_cnt + 1'b1;
            end
            else if (w.status == MIDI_START || w.status == MIDI_STOP)
            begin
                tick_cnt = '0;
            end
        end
        r.ticks = TOTAL_WIDTH'(tick_cnt);
        r.iv    = spacing_ms;
        return r;
    endfunction

    // Clock runs with spacing around the bounds as the largest share, plus queries and noise
    function automatic midi_word_t next_random_word();
        midi_word_t            w;
        logic [NOW_WIDTH-1:0]  gap;
        int                    pick;
        pick     = $urandom_range(0, 99);
        w.cmd    = CMD_MESSAGE;
        w.status = MIDI_CLOCK;
        w.len    = LEN_WIDTH'($urandom_range(1, 7));
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                gap = (min_ms <= max_ms) ? NOW_WIDTH'($urandom_range(min_ms, max_ms))
                                         : NOW_WIDTH'($urandom_range(0, 1000));
            4:       gap = NOW_WIDTH'(min_ms) - 1'b1;
            5:       gap = NOW_WIDTH'(max_ms) + 1'b1;
            6:       gap = NOW_WIDTH'(min_ms);
            7:       gap = NOW_WIDTH'(max_ms);
            8:       gap = NOW_WIDTH'($urandom_range(0, 65535));
            default: gap = NOW_WIDTH'({$urandom, $urandom});
        endcase
        if (pick < 25)
        begin
            w.cmd    = CMD_QUERY;
            w.status = STATUS_WIDTH'($urandom_range(0, 255));
            w.len    = LEN_WIDTH'($urandom_range(0, 7));
            if ($urandom_range(0, 9) != 0)
                gap = NOW_WIDTH'($urandom_range(0, 2 * spacing_ms + 2));
        end
        else if (pick < 70)
        begin
            // clock word as set up above
        end
        else if (pick < 78)
        begin
            w.status = ($urandom_range(0, 1) == 0) ? MIDI_START : MIDI_STOP;
        end
        else if (pick < 88)
        begin
            w.status = STATUS_WIDTH'($urandom_range(0, 255));
            w.len    = LEN_WIDTH'($urandom_range(0, 7));
        end
        else
        begin
            w.len = '0;
            case ($urandom_range(0, 2))
                0:       w.status = MIDI_CLOCK;
                1:       w.status = MIDI_START;
                default: w.status = MIDI_STOP;
            endcase
        end
        w.now = NOW_WIDTH'(last_ms) + gap;
        return w;
    endfunction

    // Offer one word, hold it until taken, then queue its expected report
    task automatic send_word(input midi_word_t w, input logic typed, input beat_report_t want);
        beat_report_t predicted;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid       <= 1'b1;
        command        <= w.cmd;
        status_byte    <= w.status;
        message_length <= w.len;
        now_ms         <= w.now;
        do @(posedge clk); while (in_stall);
        words_sent++;
        predicted = track_word(w);
        reports_due.push_back(typed ? want : predicted);
    endtask

    // Drop valid and hold until every queued report has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    // Write all three registers on consecutive edges; upper data byte is noise for cpb
    task automatic write_regs(input logic [IV_WIDTH-1:0] lo, input logic [IV_WIDTH-1:0] hi,
                              input logic [CPB_WIDTH-1:0] cpb);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MIN_INTERVAL;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= REG_MAX_INTERVAL;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= REG_CLOCKS_PER_BEAT;
        cfg_data  <= {8'($urandom_range(0, 255)), cpb};
        @(posedge clk);
        cfg_we  <= 1'b0;
        min_ms  = lo;
        max_ms  = hi;
        cpb_reg = cpb;
        settings_written++;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // Receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Compare each taken result with the oldest expected report
    always @(posedge clk)
    begin
        beat_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (reports_due.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: unexpected result, expected none, got beat %0h ticks %0h iv %0h",
                         $time, beat_q16, tick_total, interval_now);
            end
            else
            begin
                want = reports_due.pop_front();
                check_field("beat_q16", 64'(want.beat), 64'(beat_q16));
                check_field("tick_total", 64'(want.ticks), 64'(tick_total));
                check_field("interval_now", 64'(want.iv), 64'(interval_now));
            end
        end
    end

    // Abort when no word moves on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t ns: no word moved for %0d cycles, %0d reports outstanding",
                     $time, QUIET_LIMIT, reports_due.size());
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int                   i;
        int                   ph;
        int                   k;
        midi_word_t           w;
        beat_report_t         want;
        logic [IV_WIDTH-1:0]  lo;
        logic [IV_WIDTH-1:0]  hi;
        logic [CPB_WIDTH-1:0] cpb;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (i = 0; i < STEPS; i++)
        begin
            if (script[i].kind == ROW_REGS)
            begin
                drain();
                write_regs(script[i].beat[IV_WIDTH-1:0], script[i].ticks[IV_WIDTH-1:0],
                           script[i].iv[CPB_WIDTH-1:0]);
            end
            else
            begin
                w    = '{script[i].cmd, script[i].status, script[i].len, script[i].now};
                want = '{script[i].beat, script[i].ticks, script[i].iv};
                send_word(w, script[i].kind == ROW_TYPED, want);
            end
        end

        // Random phases, each under its own register setting, with an idle pattern per pair of phases
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain();
            send_idle_pct = (ph < 2) ? 11 : (ph < 4) ? 47 : 0;
            recv_idle_pct = (ph < 2) ? 47 : (ph < 4) ? 11 : 0;
            case (ph)
                0: begin lo = RST_MIN_INTERVAL; hi = RST_MAX_INTERVAL; cpb = RST_CPB; end
                1: begin lo = 16'd1;  hi = 16'd65535; cpb = 8'd1;   end
                2: begin lo = 16'd40; hi = 16'd30;    cpb = 8'd24;  end
                3: begin lo = 16'd1;  hi = 16'd1;     cpb = 8'd255; end
                4:
                begin
                    lo  = IV_WIDTH'($urandom_range(1, 200));
                    hi  = IV_WIDTH'($urandom_range(lo, 2000));
                    cpb = CPB_WIDTH'($urandom_range(1, 255));
                end
                default:
                begin
                    lo  = '0;
                    hi  = IV_WIDTH'($urandom_range(100, 65535));
                    cpb = '0;
                end
            endcase
            write_regs(lo, hi, cpb);
            for (k = 0; k < RANDOM_PER_PHASE; k++)
            begin
                // hold off mid-phase until the block has answered everything
                if (k == RANDOM_PER_PHASE / 2)
                    drain();
                send_word(next_random_word(), 1'b0, '0);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run: %0d words in, %0d results compared, %0d register settings.",
                 words_sent, results_seen, settings_written);
        $display("Run: spacing at and past both bounds, inverted bounds, zero interval, %s",
                 "zero clocks per beat, time wrap, saturation.");
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/mcbt_pkg.sv
hw/rtl/mcbt_div.sv
hw/rtl/midi_clock_beat_tracker.sv
hw/rtl/mcbt_checker.sv
sim/tb_top.sv
